### sv/stks_pkg.sv
// shared constants and types for the streaming top-k selector
`timescale 1ns / 1ps

package stks_pkg;

    // default sizing
    localparam int MAX_K_DEF   = 32;
    localparam int ID_BITS_DEF = 24;

    // fixed field widths
    localparam int SCORE_W = 32;
    localparam int DOC_W   = 24;
    localparam int CFG_W   = 6;

    // value of k after reset
    localparam logic [CFG_W-1:0] K_RESET = 6'd10;

    // per-cell control
    typedef struct packed {
        logic en;     // cell lies inside the active k
        logic clr;    // drop the held entry
        logic drain;  // take the neighbor entry (output sweep)
        logic ins;    // candidate insertion
    } cell_ctrl_t;

endpackage

### sv/stks_cell.sv
// one slot of the sorted list: compare against the candidate and shift
`timescale 1ns / 1ps

module stks_cell #(
    parameter int ID_W = stks_pkg::ID_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  stks_pkg::cell_ctrl_t              ctrl,
    input  logic signed [stks_pkg::SCORE_W-1:0] cand_score,
    input  logic [ID_W-1:0]                   cand_id,
    input  logic                              prev_valid,
    input  logic signed [stks_pkg::SCORE_W-1:0] prev_score,
    input  logic [ID_W-1:0]                   prev_id,
    input  logic                              prev_win,
    output logic                              valid,
    output logic signed [stks_pkg::SCORE_W-1:0] score,
    output logic [ID_W-1:0]                   id,
    output logic                              win
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [stks_pkg::SCORE_W-1:0] score_reg;
    logic signed [stks_pkg::SCORE_W-1:0] score_next;
    logic [ID_W-1:0]                   id_reg;
    logic [ID_W-1:0]                   id_next;

    // candidate ranks above this slot; an empty slot loses to anything
    always_comb
    begin
        win = !valid_reg || (cand_score > score_reg)
            || ((cand_score == score_reg) && (cand_id > id_reg));
    end

    // slot update
    always_comb
    begin
        valid_next = valid_reg;
        score_next = score_reg;
        id_next    = id_reg;
        priority if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.en && (ctrl.drain || (ctrl.ins && prev_win)))
        begin
            valid_next = prev_valid;
            score_next = prev_score;
            id_next    = prev_id;
        end
        else if (ctrl.en && ctrl.ins && win)
        begin
            valid_next = 1'b1;
            score_next = cand_score;
            id_next    = cand_id;
        end
    end

    // control bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        id_reg    <= id_next;
    end

    assign valid = valid_reg;
    assign score = score_reg;
    assign id    = id_reg;

endmodule

### sv/streaming_top_k_selector.sv
// streaming top-k selector: chain of compare-and-shift cells with output sweep
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_stall   action, score, doc_id, already_judged
//   output    out        out_valid/out_stall result_id, slot_filled, last_result
//   config    in         cfg_we              cfg_wdata (k_in_use)
//
// offers may follow each other every cycle while no sweep stalls the input
// a finish stalls the input while the k slots are swept out, one slot per cycle unless the output stalls
// the sweep goes through the single output register fed from the top active cell
// reset clears all slots and sets k to 10; a config write clears all slots
`timescale 1ns / 1ps

module streaming_top_k_selector #(
    parameter int MAX_K   = stks_pkg::MAX_K_DEF,
    parameter int ID_BITS = stks_pkg::ID_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic signed [stks_pkg::SCORE_W-1:0] score,
    input  logic [stks_pkg::DOC_W-1:0]        doc_id,
    input  logic                              already_judged,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [stks_pkg::DOC_W-1:0]        result_id,
    output logic                              slot_filled,
    output logic                              last_result,
    input  logic                              cfg_we,
    input  logic [stks_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int ID_W  = (ID_BITS < stks_pkg::DOC_W) ? ID_BITS : stks_pkg::DOC_W;
    localparam int KW    = $clog2(MAX_K + 1);
    localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                          state_reg;
    logic                          state_next;
    logic [stks_pkg::CFG_W-1:0]    k_reg;
    logic [stks_pkg::CFG_W-1:0]    k_next;
    logic [KW-1:0]                 cnt_reg;
    logic [KW-1:0]                 cnt_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [stks_pkg::DOC_W-1:0]    result_id_reg;
    logic [stks_pkg::DOC_W-1:0]    result_id_next;
    logic                          slot_filled_reg;
    logic                          slot_filled_next;
    logic                          last_result_reg;
    logic                          last_result_next;

    logic [KW-1:0]                 k_eff;
    logic [IDX_W-1:0]              top_idx;
    logic                          in_take;
    logic                          do_ins;
    logic                          drain_go;
    logic [ID_W-1:0]               cand_id;

    logic                          cell_valid [MAX_K];
    logic signed [stks_pkg::SCORE_W-1:0] cell_score [MAX_K];
    logic [ID_W-1:0]               cell_id    [MAX_K];
    logic                          cell_win   [MAX_K];

    // clamp k into 1..MAX_K
    always_comb
    begin
        priority if (k_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (int'(k_reg) > MAX_K)
        begin
            k_eff = KW'(MAX_K);
        end
        else
        begin
            k_eff = KW'(k_reg);
        end
    end

    assign top_idx  = IDX_W'(k_eff - KW'(1));
    assign in_stall = (state_reg == ST_DRAIN);
    assign in_take  = in_valid && !in_stall;
    assign do_ins   = in_take && !action && !already_judged;
    assign drain_go = (state_reg == ST_DRAIN) && (!out_valid_reg || !out_stall);
    assign cand_id  = ID_W'(doc_id);

    // cell chain
    for (genvar i = 0; i < MAX_K; i++)
    begin : g_cell
        stks_pkg::cell_ctrl_t ctrl;
        logic                 p_valid;
        logic signed [stks_pkg::SCORE_W-1:0] p_score;
        logic [ID_W-1:0]      p_id;
        logic                 p_win;

        assign ctrl.en    = (KW'(i) < k_eff);
        assign ctrl.clr   = cfg_we;
        assign ctrl.drain = drain_go;
        assign ctrl.ins   = do_ins;

        if (i == 0)
        begin : g_head
            assign p_valid = 1'b0;
            assign p_score = '0;
            assign p_id    = '0;
            assign p_win   = 1'b0;
        end
        else
        begin : g_link
            assign p_valid = cell_valid[i-1];
            assign p_score = cell_score[i-1];
            assign p_id    = cell_id[i-1];
            assign p_win   = cell_win[i-1];
        end

        stks_cell #(
            .ID_W (ID_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .cand_score (score),
            .cand_id    (cand_id),
            .prev_valid (p_valid),
            .prev_score (p_score),
            .prev_id    (p_id),
            .prev_win   (p_win),
            .valid      (cell_valid[i]),
            .score      (cell_score[i]),
            .id         (cell_id[i]),
            .win        (cell_win[i])
        );
    end

    // sequencer and output register
    always_comb
    begin
        state_next       = state_reg;
        k_next           = k_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        result_id_next   = result_id_reg;
        slot_filled_next = slot_filled_reg;
        last_result_next = last_result_reg;

        if (cfg_we)
        begin
            k_next = cfg_wdata;
        end

        if (in_take && action)
        begin
            state_next = ST_DRAIN;
            cnt_next   = k_eff;
        end

        priority if (drain_go)
        begin
            out_valid_next   = 1'b1;
            slot_filled_next = cell_valid[top_idx];
            result_id_next   = cell_valid[top_idx]
                             ? stks_pkg::DOC_W'(cell_id[top_idx]) : '0;
            last_result_next = (cnt_reg == KW'(1));
            cnt_next         = cnt_reg - KW'(1);
            if (cnt_reg == KW'(1))
            begin
                state_next = ST_IDLE;
            end
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= stks_pkg::K_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        result_id_reg   <= result_id_next;
        slot_filled_reg <= slot_filled_next;
        last_result_reg <= last_result_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_id   = result_id_reg;
    assign slot_filled = slot_filled_reg;
    assign last_result = last_result_reg;

endmodule

### sv/stks_checker.sv
// port-level checks for the streaming top-k selector, bound to the top level
`timescale 1ns / 1ps

module stks_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       action,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [stks_pkg::DOC_W-1:0] result_id,
    input logic                       slot_filled,
    input logic                       last_result
);

    // a held result transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_id)
            && $stable(slot_filled) && $stable(last_result))
        else $error("output payload changed while stalled");

    // an empty slot reports id zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !slot_filled |-> result_id == '0)
        else $error("empty slot with nonzero id");

    // an accepted finish starts the output sweep
    a_finish_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action |=> in_stall)
        else $error("finish did not start the sweep");

    // the sweep ends with the best slot in the output register
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid && last_result)
        else $error("sweep ended without the last result");

endmodule

bind streaming_top_k_selector stks_checker u_stks_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_id   (result_id),
    .slot_filled (slot_filled),
    .last_result (last_result)
);
